FILE: rtl/core/dcs_pkg.sv
package dcs_pkg;

  localparam int WIN_DEPTH = 4;
  localparam int CNT_W     = 3;
  localparam int E_W       = 16;
  localparam int P_W       = 13;
  localparam int T_W       = 62;
  localparam int G_W       = 63;   // signed gap between two stored times
  localparam int GAP_W     = 40;
  localparam int TRIG_W    = 32;
  localparam int CELL_W    = 7;
  localparam int DSQ_W     = 30;
  localparam int RSQ_W     = 27;
  localparam int ZS_W      = 14;
  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;

  localparam logic [29:0]       NSEC_PER_SEC  = 30'd1000000000;
  localparam logic [DSQ_W-1:0]  DIST_LIMIT_SQ = 30'd25000000;
  localparam int                RSQ_BAND      = 400000;
  localparam int                Z_OFFSET      = 2000;
  localparam int                Z_BAND        = 400;
  localparam int                BANDS         = 10;
  localparam logic [CELL_W-1:0] CELL_NONE     = 7'd100;

  localparam logic KIND_PAIR   = 1'b0;
  localparam logic KIND_SINGLE = 1'b1;

  localparam logic [2:0] REG_PE_LO     = 3'd0;
  localparam logic [2:0] REG_PE_HI     = 3'd1;
  localparam logic [2:0] REG_DE_LO     = 3'd2;
  localparam logic [2:0] REG_DE_HI     = 3'd3;
  localparam logic [2:0] REG_CAP_WIN   = 3'd4;
  localparam logic [2:0] REG_CAP_MIN   = 3'd5;
  localparam logic [2:0] REG_PRE_VETO  = 3'd6;
  localparam logic [2:0] REG_POST_VETO = 3'd7;

  typedef struct packed {
    logic [E_W-1:0]         energy;
    logic signed [P_W-1:0]  x;
    logic signed [P_W-1:0]  y;
    logic signed [P_W-1:0]  z;
    logic [T_W-1:0]         stamp;
    logic [TRIG_W-1:0]      trig;
    logic [CELL_W-1:0]      cell_id;
  } entry_t;

  typedef entry_t [WIN_DEPTH-1:0] row_t;

  typedef struct packed {
    logic [E_W-1:0]   pe_lo;
    logic [E_W-1:0]   pe_hi;
    logic [E_W-1:0]   de_lo;
    logic [E_W-1:0]   de_hi;
    logic [GAP_W-1:0] cap_win;
    logic [GAP_W-1:0] cap_min;
    logic [GAP_W-1:0] pre_veto;
    logic [GAP_W-1:0] post_veto;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [2:0]        det_out;
    logic [TRIG_W-1:0] first_trigger;
    logic [TRIG_W-1:0] second_trigger;
    logic [E_W-1:0]    first_energy;
    logic [E_W-1:0]    second_energy;
    logic [CELL_W-1:0] cell_res;
    logic [GAP_W-1:0]  gap_before_ns;
    logic [GAP_W-1:0]  gap_after_ns;
    logic [GAP_W-1:0]  pair_gap_ns;
    logic [27:0]       pair_dist_sq;
  } result_t;

  function automatic logic [GAP_W-1:0] sat_gap(input logic signed [G_W-1:0] g);
    logic [GAP_W-1:0] r;
    if (g < 0) begin
      r = '0;
    end else if (g[G_W-1:GAP_W] != '0) begin
      r = '1;
    end else begin
      r = g[GAP_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/dcs_ifs.sv
interface dcs_in_if import dcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [2:0]            detector;
  logic [E_W-1:0]        energy_kev;
  logic signed [P_W-1:0] pos_x;
  logic signed [P_W-1:0] pos_y;
  logic signed [P_W-1:0] pos_z;
  logic [31:0]           stamp_sec;
  logic [29:0]           stamp_nsec;
  logic [TRIG_W-1:0]     trigger_number;

  modport source (output valid, detector, energy_kev, pos_x, pos_y, pos_z,
                  stamp_sec, stamp_nsec, trigger_number, input ready);
  modport sink (input valid, detector, energy_kev, pos_x, pos_y, pos_z,
                stamp_sec, stamp_nsec, trigger_number, output ready);
endinterface

interface dcs_out_if import dcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [2:0]        det_out;
  logic [TRIG_W-1:0] first_trigger;
  logic [TRIG_W-1:0] second_trigger;
  logic [E_W-1:0]    first_energy;
  logic [E_W-1:0]    second_energy;
  logic [CELL_W-1:0] cell_res;
  logic [GAP_W-1:0]  gap_before_ns;
  logic [GAP_W-1:0]  gap_after_ns;
  logic [GAP_W-1:0]  pair_gap_ns;
  logic [27:0]       pair_dist_sq;

  modport source (output valid, kind, det_out, first_trigger, second_trigger,
                  first_energy, second_energy, cell_res, gap_before_ns,
                  gap_after_ns, pair_gap_ns, pair_dist_sq, input ready);
  modport sink (input valid, kind, det_out, first_trigger, second_trigger,
                first_energy, second_energy, cell_res, gap_before_ns,
                gap_after_ns, pair_gap_ns, pair_dist_sq, output ready);
endinterface

FILE: rtl/core/dcs_cfg.sv
module dcs_cfg import dcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pe_lo     <= 16'd1500;
      cfg_r.pe_hi     <= 16'd12000;
      cfg_r.de_lo     <= 16'd1900;
      cfg_r.de_hi     <= 16'd12000;
      cfg_r.cap_win   <= 40'd400000;
      cfg_r.cap_min   <= 40'd1000;
      cfg_r.pre_veto  <= 40'd800000;
      cfg_r.post_veto <= 40'd400000;
    end else if (wr) begin
      unique case (idx)
        REG_PE_LO:     cfg_r.pe_lo     <= pwdata[E_W-1:0];
        REG_PE_HI:     cfg_r.pe_hi     <= pwdata[E_W-1:0];
        REG_DE_LO:     cfg_r.de_lo     <= pwdata[E_W-1:0];
        REG_DE_HI:     cfg_r.de_hi     <= pwdata[E_W-1:0];
        REG_CAP_WIN:   cfg_r.cap_win   <= pwdata[GAP_W-1:0];
        REG_CAP_MIN:   cfg_r.cap_min   <= pwdata[GAP_W-1:0];
        REG_PRE_VETO:  cfg_r.pre_veto  <= pwdata[GAP_W-1:0];
        REG_POST_VETO: cfg_r.post_veto <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PE_LO:     prdata = CFG_DW'(cfg_r.pe_lo);
      REG_PE_HI:     prdata = CFG_DW'(cfg_r.pe_hi);
      REG_DE_LO:     prdata = CFG_DW'(cfg_r.de_lo);
      REG_DE_HI:     prdata = CFG_DW'(cfg_r.de_hi);
      REG_CAP_WIN:   prdata = CFG_DW'(cfg_r.cap_win);
      REG_CAP_MIN:   prdata = CFG_DW'(cfg_r.cap_min);
      REG_PRE_VETO:  prdata = CFG_DW'(cfg_r.pre_veto);
      REG_POST_VETO: prdata = CFG_DW'(cfg_r.post_veto);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/delayed_coincidence_selector.sv
// Timing: an item is taken and its detector's window row read at the same
//   edge; the row is tested in stages 1 and 2 and written back as stage 2
//   advances, at the same edge that registers the result.
// Throughput: one item per cycle across different detectors while the output
//   is not stalled; an item for a detector still in the read-modify-write loop
//   waits until the row write lands. The hazard check on that loop sets this.
// Reset: synchronous active-low; clears window counts, pipeline and output.
module delayed_coincidence_selector import dcs_pkg::*; #(
  parameter int NUM_DETECTORS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  dcs_in_if.sink            in_ch,
  dcs_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int DET_AW = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;

  cfg_t cfg;

  dcs_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // Window storage: one row (all four entries) per detector. Counts live in
  // flops so that reset can clear them.
  row_t             mem [NUM_DETECTORS];
  logic [CNT_W-1:0] cnt_r [NUM_DETECTORS];

  // ---------------- accept / read issue ----------------
  logic              in_fire, in_ok, haz, adv, hold;
  logic [DET_AW-1:0] in_idx;

  // stage 1: row read back, new item held
  logic                  v1_r;
  logic [DET_AW-1:0]     idx1_r;
  row_t                  rd_row_r;
  logic [E_W-1:0]        e1n_r;
  logic signed [P_W-1:0] x1_r, y1_r, z1_r;
  logic [31:0]           sec1_r;
  logic [29:0]           nsec1_r;
  logic [TRIG_W-1:0]     trig1_r;

  // stage 2: window tests, row write back
  logic                   v2_r;
  logic [DET_AW-1:0]      idx2_r;
  logic [CNT_W-1:0]       cnt2_r;
  row_t                   row2_r;
  logic signed [G_W-1:0]  g10_r, g21_r, g20_r, g32_r;
  logic [27:0]            dx2_r, dy2_r, dz2_r;
  logic [WIN_DEPTH-1:0]   pl_r, dl_r;
  logic [E_W-1:0]         e2n_r;
  logic signed [P_W-1:0]  x2_r, y2_r, z2_r;
  logic [T_W-1:0]         t2n_r;
  logic [TRIG_W-1:0]      trig2_r;
  logic [RSQ_W-1:0]       rsq2_r;
  logic signed [ZS_W-1:0] zs2_r;

  logic    out_valid_r;
  result_t out_r;

  logic    res_valid;
  result_t res;

  assign in_idx  = DET_AW'(in_ch.detector);
  assign in_ok   = 32'(in_ch.detector) < NUM_DETECTORS;
  // Same-detector items are held off until the row write lands.
  assign haz     = (v1_r && idx1_r == in_idx) || (v2_r && idx2_r == in_idx);
  // Only a new result meeting a full output register stalls the pipe.
  assign hold    = v2_r && res_valid && out_valid_r && !out_ch.ready;
  assign adv     = !hold;
  assign in_ch.ready = adv && !haz;
  assign in_fire = in_ch.valid && in_ch.ready;

  // ---------------- stage 1 datapath ----------------
  logic [T_W-1:0]         t_new;
  logic signed [25:0]     xx, yy;
  logic [RSQ_W-1:0]       rsq_new;
  logic signed [ZS_W-1:0] zs_new;
  logic signed [G_W-1:0]  g10, g21, g20, g32;
  logic signed [13:0]     dx, dy, dz;
  logic signed [27:0]     dxs, dys, dzs;
  logic [WIN_DEPTH-1:0]   pl, dl;

  always_comb begin
    t_new   = T_W'(sec1_r) * T_W'(NSEC_PER_SEC) + T_W'(nsec1_r);
    xx      = x1_r * x1_r;
    yy      = y1_r * y1_r;
    rsq_new = RSQ_W'($unsigned(xx)) + RSQ_W'($unsigned(yy));
    zs_new  = z1_r + ZS_W'(Z_OFFSET);
    g10 = $signed({1'b0, rd_row_r[1].stamp}) - $signed({1'b0, rd_row_r[0].stamp});
    g21 = $signed({1'b0, rd_row_r[2].stamp}) - $signed({1'b0, rd_row_r[1].stamp});
    g20 = $signed({1'b0, rd_row_r[2].stamp}) - $signed({1'b0, rd_row_r[0].stamp});
    g32 = $signed({1'b0, rd_row_r[3].stamp}) - $signed({1'b0, rd_row_r[2].stamp});
    dx  = rd_row_r[2].x - rd_row_r[1].x;
    dy  = rd_row_r[2].y - rd_row_r[1].y;
    dz  = rd_row_r[2].z - rd_row_r[1].z;
    dxs = dx * dx;
    dys = dy * dy;
    dzs = dz * dz;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      pl[i] = rd_row_r[i].energy > cfg.pe_lo && rd_row_r[i].energy < cfg.pe_hi;
      dl[i] = rd_row_r[i].energy > cfg.de_lo && rd_row_r[i].energy < cfg.de_hi;
    end
  end

  // ---------------- stage 2 datapath ----------------
  logic [DSQ_W-1:0]  dsq;
  logic              veto, sveto, pair, single, full;
  logic [3:0]        band_a, band_b;
  logic              cell_ok;
  entry_t            ent_new;
  row_t              row_nxt;
  logic [CNT_W-1:0]  cnt_nxt;

  function automatic logic below(input logic signed [G_W-1:0] g,
                                 input logic [GAP_W-1:0] lim);
    return g < $signed({{(G_W-GAP_W){1'b0}}, lim});
  endfunction

  always_comb begin
    dsq = DSQ_W'(dx2_r) + DSQ_W'(dy2_r) + DSQ_W'(dz2_r);
    full = cnt2_r == CNT_W'(WIN_DEPTH);
    veto  = (below(g20_r, cfg.pre_veto) && pl_r[0]) ||
            (below(g32_r, cfg.post_veto) && dl_r[3]);
    sveto = (below(g10_r, cfg.pre_veto) && pl_r[0]) ||
            (below(g21_r, cfg.post_veto) && dl_r[2]);
    pair = pl_r[1] && dl_r[2] &&
           (g21_r > $signed({{(G_W-GAP_W){1'b0}}, cfg.cap_min})) &&
           below(g21_r, cfg.cap_win) && !veto && dsq < DIST_LIMIT_SQ &&
           row2_r[1].cell_id == row2_r[2].cell_id && row2_r[2].cell_id != CELL_NONE;
    single = !pair && pl_r[1] && !sveto && row2_r[1].cell_id != CELL_NONE;
    res_valid = full && (pair || single);

    // cell of the new event: radius-squared bands and z bands, truncating
    // toward zero (a small negative z offset still lands in band zero)
    band_a = '0;
    band_b = '0;
    for (int k = 1; k < BANDS; k++) begin
      if (rsq2_r >= RSQ_W'(RSQ_BAND * k)) band_a = band_a + 4'd1;
      if (zs2_r >= $signed(ZS_W'(Z_BAND * k))) band_b = band_b + 4'd1;
    end
    cell_ok = rsq2_r < RSQ_W'(RSQ_BAND * BANDS) &&
              zs2_r > -$signed(ZS_W'(Z_BAND)) &&
              zs2_r < $signed(ZS_W'(Z_BAND * BANDS));

    ent_new.energy  = e2n_r;
    ent_new.x       = x2_r;
    ent_new.y       = y2_r;
    ent_new.z       = z2_r;
    ent_new.stamp   = t2n_r;
    ent_new.trig    = trig2_r;
    ent_new.cell_id = cell_ok ? CELL_W'(int'(band_a) * BANDS + int'(band_b)) : CELL_NONE;

    row_nxt = row2_r;
    if (full && pair) begin
      row_nxt[0] = row2_r[2];
      row_nxt[1] = row2_r[3];
      row_nxt[2] = ent_new;
      cnt_nxt    = CNT_W'(WIN_DEPTH - 1);
    end else if (full) begin
      row_nxt[0] = row2_r[1];
      row_nxt[1] = row2_r[2];
      row_nxt[2] = row2_r[3];
      row_nxt[3] = ent_new;
      cnt_nxt    = CNT_W'(WIN_DEPTH);
    end else begin
      row_nxt[cnt2_r[1:0]] = ent_new;
      cnt_nxt = cnt2_r + CNT_W'(1);
    end

    res.det_out       = 3'(idx2_r);
    res.first_trigger = row2_r[1].trig;
    res.first_energy  = row2_r[1].energy;
    res.cell_res      = row2_r[1].cell_id;
    if (pair) begin
      res.kind           = KIND_PAIR;
      res.second_trigger = row2_r[2].trig;
      res.second_energy  = row2_r[2].energy;
      res.gap_before_ns  = sat_gap(g20_r);
      res.gap_after_ns   = sat_gap(g32_r);
      res.pair_gap_ns    = sat_gap(g21_r);
      res.pair_dist_sq   = dsq[27:0];
    end else begin
      res.kind           = KIND_SINGLE;
      res.second_trigger = '0;
      res.second_energy  = '0;
      res.gap_before_ns  = sat_gap(g10_r);
      res.gap_after_ns   = sat_gap(g21_r);
      res.pair_gap_ns    = '0;
      res.pair_dist_sq   = '0;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_DETECTORS; i++) cnt_r[i] <= '0;
    end else begin
      if (adv) begin
        v1_r <= in_fire && in_ok;
        v2_r <= v1_r;
      end
      if (v2_r && adv) cnt_r[idx2_r] <= cnt_nxt;
      if (v2_r && adv && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- memory and payload ----------------
  always_ff @(posedge clk) begin
    if (v2_r && adv) mem[idx2_r] <= row_nxt;
    if (in_fire) rd_row_r <= mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx1_r  <= in_idx;
      e1n_r   <= in_ch.energy_kev;
      x1_r    <= in_ch.pos_x;
      y1_r    <= in_ch.pos_y;
      z1_r    <= in_ch.pos_z;
      sec1_r  <= in_ch.stamp_sec;
      nsec1_r <= in_ch.stamp_nsec;
      trig1_r <= in_ch.trigger_number;
    end
    if (adv) begin
      idx2_r  <= idx1_r;
      cnt2_r  <= cnt_r[idx1_r];
      row2_r  <= rd_row_r;
      g10_r   <= g10;
      g21_r   <= g21;
      g20_r   <= g20;
      g32_r   <= g32;
      dx2_r   <= 28'($unsigned(dxs));
      dy2_r   <= 28'($unsigned(dys));
      dz2_r   <= 28'($unsigned(dzs));
      pl_r    <= pl;
      dl_r    <= dl;
      e2n_r   <= e1n_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      z2_r    <= z1_r;
      t2n_r   <= t_new;
      trig2_r <= trig1_r;
      rsq2_r  <= rsq_new;
      zs2_r   <= zs_new;
    end
    if (v2_r && adv && res_valid) out_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.det_out        = out_r.det_out;
  assign out_ch.first_trigger  = out_r.first_trigger;
  assign out_ch.second_trigger = out_r.second_trigger;
  assign out_ch.first_energy   = out_r.first_energy;
  assign out_ch.second_energy  = out_r.second_energy;
  assign out_ch.cell_res       = out_r.cell_res;
  assign out_ch.gap_before_ns  = out_r.gap_before_ns;
  assign out_ch.gap_after_ns   = out_r.gap_after_ns;
  assign out_ch.pair_gap_ns    = out_r.pair_gap_ns;
  assign out_ch.pair_dist_sq   = out_r.pair_dist_sq;

  // ---------------- checks ----------------
  // no two items of one detector in the read-modify-write loop at once
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r) |-> (idx1_r != idx2_r))
    else $error("same detector in both window stages");

  // a result only ever comes from a full window
  a_res_full: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && res_valid) |-> (cnt2_r == CNT_W'(WIN_DEPTH)))
    else $error("result from a window that is not full");

  // a pair always carries a valid cell
  a_pair_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_PAIR) |-> (out_r.cell_res != CELL_NONE))
    else $error("pair result without a valid cell");

endmodule

FILE: test/delayed_coincidence_selector_checker.sv
module delayed_coincidence_selector_checker import dcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dcs_in_if                 in_ch,
  dcs_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending
);

  typedef struct {
    logic [E_W-1:0]    energy;
    longint            x, y, z;
    longint            stamp;
    logic [TRIG_W-1:0] trig;
  } event_t;

  cfg_t    thr;
  event_t  win [8][WIN_DEPTH];
  int      fill [8];
  result_t awaited [$];

  assign pending = awaited.size();

  function automatic bit prompt_e(logic [E_W-1:0] e);
    return e > thr.pe_lo && e < thr.pe_hi;
  endfunction

  function automatic bit delayed_e(logic [E_W-1:0] e);
    return e > thr.de_lo && e < thr.de_hi;
  endfunction

  function automatic logic [GAP_W-1:0] clamp_gap(longint g);
    if (g < 0) return '0;
    if (g > longint'(40'hFF_FFFF_FFFF)) return '1;
    return g[GAP_W-1:0];
  endfunction

  // 10 radius-squared bands x 10 z bands, 100 when outside
  function automatic int cell_index(event_t v);
    longint a, b;
    a = (v.x * v.x + v.y * v.y) / 400000;
    b = (v.z + 2000) / 400;
    if (a >= 0 && a < 10 && b >= 0 && b < 10) return int'(10 * a + b);
    return int'(CELL_NONE);
  endfunction

  function automatic void shift_window(int d, int n);
    for (int i = 0; i + n < WIN_DEPTH; i++) win[d][i] = win[d][i + n];
    fill[d] -= n;
  endfunction

  task automatic select_event(event_t v, int d);
    result_t r;
    int c1, c2;
    longint g20, g32, g21, g10, dx, dy, dz, dsq;
    bit veto, pair, sveto;
    if (fill[d] >= WIN_DEPTH) begin
      c1  = cell_index(win[d][1]);
      c2  = cell_index(win[d][2]);
      g20 = win[d][2].stamp - win[d][0].stamp;
      g32 = win[d][3].stamp - win[d][2].stamp;
      g21 = win[d][2].stamp - win[d][1].stamp;
      g10 = win[d][1].stamp - win[d][0].stamp;
      dx  = win[d][2].x - win[d][1].x;
      dy  = win[d][2].y - win[d][1].y;
      dz  = win[d][2].z - win[d][1].z;
      dsq = dx * dx + dy * dy + dz * dz;
      veto = (g20 < longint'(thr.pre_veto) && prompt_e(win[d][0].energy)) ||
             (g32 < longint'(thr.post_veto) && delayed_e(win[d][3].energy));
      pair = prompt_e(win[d][1].energy) && delayed_e(win[d][2].energy) &&
             g21 > longint'(thr.cap_min) && g21 < longint'(thr.cap_win) &&
             !veto && dsq < 25000000 && c1 == c2 && c2 < int'(CELL_NONE);
      r = '0;
      r.det_out       = d[2:0];
      r.first_trigger = win[d][1].trig;
      r.first_energy  = win[d][1].energy;
      r.cell_res      = c1[CELL_W-1:0];
      if (pair) begin
        r.kind           = KIND_PAIR;
        r.second_trigger = win[d][2].trig;
        r.second_energy  = win[d][2].energy;
        r.gap_before_ns  = clamp_gap(g20);
        r.gap_after_ns   = clamp_gap(g32);
        r.pair_gap_ns    = clamp_gap(g21);
        r.pair_dist_sq   = dsq[27:0];
        awaited = {awaited, r};
        shift_window(d, 2);
      end else begin
        sveto = (g10 < longint'(thr.pre_veto) && prompt_e(win[d][0].energy)) ||
                (g21 < longint'(thr.post_veto) && delayed_e(win[d][2].energy));
        if (prompt_e(win[d][1].energy) && !sveto && c1 < int'(CELL_NONE)) begin
          r.kind          = KIND_SINGLE;
          r.gap_before_ns = clamp_gap(g10);
          r.gap_after_ns  = clamp_gap(g21);
          awaited = {awaited, r};
        end
        shift_window(d, 1);
      end
    end
    win[d][fill[d]] = v;
    fill[d]++;
  endtask

  always @(posedge clk) begin
    event_t  v;
    result_t got;
    if (!rst_n) begin
      thr       <= '{16'd1500, 16'd12000, 16'd1900, 16'd12000,
                     40'd400000, 40'd1000, 40'd800000, 40'd400000};
      errors    <= 0;
      for (int i = 0; i < 8; i++) fill[i] = 0;
      awaited.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_PE_LO:     thr.pe_lo     <= pwdata[E_W-1:0];
          REG_PE_HI:     thr.pe_hi     <= pwdata[E_W-1:0];
          REG_DE_LO:     thr.de_lo     <= pwdata[E_W-1:0];
          REG_DE_HI:     thr.de_hi     <= pwdata[E_W-1:0];
          REG_CAP_WIN:   thr.cap_win   <= pwdata[GAP_W-1:0];
          REG_CAP_MIN:   thr.cap_min   <= pwdata[GAP_W-1:0];
          REG_PRE_VETO:  thr.pre_veto  <= pwdata[GAP_W-1:0];
          REG_POST_VETO: thr.post_veto <= pwdata[GAP_W-1:0];
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.det_out, out_ch.first_trigger, out_ch.second_trigger,
                out_ch.first_energy, out_ch.second_energy, out_ch.cell_res,
                out_ch.gap_before_ns, out_ch.gap_after_ns, out_ch.pair_gap_ns,
                out_ch.pair_dist_sq};
        if (awaited.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", got);
          errors <= errors + 1;
        end else begin
          if (got !== awaited[0]) begin
            if (errors < 10) $display("mismatch: expected %p\n          actual   %p",
                                      awaited[0], got);
            errors <= errors + 1;
          end
          void'(awaited.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        v.energy = in_ch.energy_kev;
        v.x      = longint'(in_ch.pos_x);
        v.y      = longint'(in_ch.pos_y);
        v.z      = longint'(in_ch.pos_z);
        v.stamp  = longint'(in_ch.stamp_sec) * 1000000000 + longint'(in_ch.stamp_nsec);
        v.trig   = in_ch.trigger_number;
        select_event(v, int'(in_ch.detector));
      end
    end
  end

endmodule

FILE: test/delayed_coincidence_selector_tb.sv
module delayed_coincidence_selector_tb import dcs_pkg::*; ();

  localparam int CYCLE_LIMIT = 2000000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  int                errors, pending;
  int                cycles = 0;
  int                idle_pct = 0;    // sender idles this often, percent
  int                stall_pct = 0;   // receiver stalls this often, percent
  longint            clock_ns [8];    // per-detector event time cursor
  int                trig_seq = 0;

  dcs_in_if  in_ch ();
  dcs_out_if out_ch ();

  always #5 clk = ~clk;

  delayed_coincidence_selector dut (
    .clk, .rst_n, .in_ch(in_ch), .out_ch(out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  delayed_coincidence_selector_checker chk (
    .clk, .rst_n, .in_ch(in_ch), .out_ch(out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending
  );

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("delayed_coincidence_selector_tb: errors");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  // APB write: setup, then access; lands on the edge closing the access
  task automatic reg_write(logic [2:0] idx, logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_thresholds(logic [15:0] pl, ph, dl, dh, logic [39:0] cw, cm, pre, post);
    reg_write(REG_PE_LO, CFG_DW'(pl));
    reg_write(REG_PE_HI, CFG_DW'(ph));
    reg_write(REG_DE_LO, CFG_DW'(dl));
    reg_write(REG_DE_HI, CFG_DW'(dh));
    reg_write(REG_CAP_WIN, CFG_DW'(cw));
    reg_write(REG_CAP_MIN, CFG_DW'(cm));
    reg_write(REG_PRE_VETO, CFG_DW'(pre));
    reg_write(REG_POST_VETO, CFG_DW'(post));
    @(posedge clk);
  endtask

  // drain everything in flight: drop valid, wait until no result is pending, then idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // hand one item over; valid stays up into the next item when back to back
  task automatic push_event(logic [2:0] det, logic [15:0] e, logic [12:0] x, y, z,
                            logic [31:0] sec, logic [29:0] nsec, logic [31:0] trig);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.detector       <= det;
    in_ch.energy_kev     <= e;
    in_ch.pos_x          <= x;
    in_ch.pos_y          <= y;
    in_ch.pos_z          <= z;
    in_ch.stamp_sec      <= sec;
    in_ch.stamp_nsec     <= nsec;
    in_ch.trigger_number <= trig;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // event at an absolute time in ns
  task automatic event_at(int det, int e, int x, int y, int z, longint t_ns);
    trig_seq++;
    push_event(det[2:0], e[15:0], x[12:0], y[12:0], z[12:0],
               32'(t_ns / 1000000000), 30'(t_ns % 1000000000), trig_seq);
  endtask

  // Random event. Most follow a physics-like stream per detector: times
  // stepping forward, prompt/delayed energies, positions clustered in one
  // cell, so pairs and singles both appear. The rest is raw noise.
  task automatic random_event();
    int     det, e, x, y, z, r;
    longint step;
    det = $urandom_range(0, 7);
    r = $urandom_range(0, 99);
    if (r < 45)      step = $urandom_range(1500, 350000);
    else if (r < 80) step = $urandom_range(400000, 3000000);
    else if (r < 90) step = $urandom_range(0, 1200);
    else             step = -longint'($urandom_range(0, 1000000));
    clock_ns[det] += step;
    if (clock_ns[det] < 0) clock_ns[det] = 0;
    r = $urandom_range(0, 99);
    if (r < 40)      e = $urandom_range(1600, 11900);
    else if (r < 75) e = $urandom_range(2000, 11900);
    else if (r < 90) e = $urandom_range(0, 1499);
    else             e = $urandom_range(0, 65535);
    if ($urandom_range(0, 99) < 85) begin
      x = $signed($urandom_range(0, 600)) - 300;
      y = $signed($urandom_range(0, 600)) - 300;
      z = -2000 + 400 * (det + 1) + 200 + $signed($urandom_range(0, 300)) - 150;
    end else begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end
    if ($urandom_range(0, 99) < 4) begin
      // full-range stamp, nsec may exceed one second
      trig_seq++;
      push_event(det[2:0], e[15:0], x[12:0], y[12:0], z[12:0], $urandom,
                 30'($urandom), $urandom);
    end else begin
      event_at(det, e, x, y, z, clock_ns[det]);
    end
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) random_event();
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.detector       = '0;
    in_ch.energy_kev     = '0;
    in_ch.pos_x          = '0;
    in_ch.pos_y          = '0;
    in_ch.pos_z          = '0;
    in_ch.stamp_sec      = '0;
    in_ch.stamp_nsec     = '0;
    in_ch.trigger_number = '0;
    for (int i = 0; i < 8; i++) clock_ns[i] = 64'd5000000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults rewritten explicitly
    load_thresholds(16'd1500, 16'd12000, 16'd1900, 16'd12000,
                    40'd400000, 40'd1000, 40'd800000, 40'd400000);

    // --- directed ---
    // clean pair on detector 1: quiet, prompt, delayed 50 us later, quiet, then flush
    event_at(1, 500,  10, 10, 100, 1000000);
    event_at(1, 5000, 20, 20, 100, 3000000);
    event_at(1, 6000, 30, 25, 120, 3050000);
    event_at(1, 500,  40, 40, 100, 6000000);
    event_at(1, 800,  0,  0,  100, 9000000);
    // pre-veto on detector 2 (prompt-like event 0 right before) vetoes both pair and single
    event_at(2, 3000, 0, 0, 0, 1000000);
    event_at(2, 4000, 0, 0, 0, 1200000);
    event_at(2, 5000, 0, 0, 0, 1230000);
    event_at(2, 100,  0, 0, 0, 5000000);
    event_at(2, 100,  0, 0, 0, 9000000);
    // z+2000 just below zero still lands in band 0; times running backward
    event_at(3, 100,  0, 0, -2100, 9000000);
    event_at(3, 5000, 0, 0, -2100, 8000000);
    event_at(3, 5000, 0, 0, -2300, 7990000);
    event_at(3, 100,  0, 0, -2100, 1000);
    event_at(3, 100,  0, 0, -2100, 0);
    // field extremes on detector 7, plus energy bounds at the registers
    push_event(3'd7, 16'hFFFF, 13'h1000, 13'h0FFF, 13'h1000, 32'hFFFF_FFFF,
               30'h3FFF_FFFF, 32'hFFFF_FFFF);
    push_event(3'd7, 16'd0, 13'h0FFF, 13'h1000, 13'h0FFF, 32'd0, 30'd0, 32'd0);
    push_event(3'd7, 16'd1500, 13'd0, 13'd0, 13'd0, 32'd1, 30'd0, 32'd7);
    push_event(3'd7, 16'd1501, 13'd0, 13'd0, 13'd0, 32'd1, 30'd1, 32'd8);
    push_event(3'd7, 16'd11999, 13'd0, 13'd0, 13'd0, 32'd2, 30'd999999999, 32'd9);
    push_event(3'd7, 16'd12000, 13'h1F00, 13'd255, 13'd0, 32'd5, 30'd0, 32'd10);
    drain();

    // --- random, no idling ---
    random_run(150);
    drain();

    // --- sender idling, looser cuts, a full pause midway ---
    load_thresholds(16'd1000, 16'd13000, 16'd1000, 16'd13000,
                    40'd1000000, 40'd0, 40'd100000, 40'd50000);
    idle_pct = 79;
    random_run(60);
    drain();
    random_run(60);
    drain();

    // --- receiver stalling, all-zero thresholds ---
    idle_pct  = 0;
    stall_pct = 79;
    load_thresholds('0, '0, '0, '0, '0, '0, '0, '0);
    random_run(60);
    drain();

    // --- both sides at 25%, all thresholds at their top ---
    idle_pct  = 25;
    stall_pct = 25;
    load_thresholds('1, '1, '1, '1, '1, '1, '1, '1);
    random_run(60);
    drain();

    // --- no idling, wide capture window and veto windows set to zero ---
    idle_pct  = 0;
    stall_pct = 0;
    load_thresholds(16'd1500, 16'd12000, 16'd1900, 16'd12000,
                    40'hFF_FFFF_FFFF, 40'd1000, 40'd0, 40'd0);
    random_run(110);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("delayed_coincidence_selector_tb: clean");
    end else begin
      $display("delayed_coincidence_selector_tb: errors");
    end
    $finish;
  end

endmodule
